FILE: sv/sld_pkg.sv
// ----------------------------------------------------------------------------
// sld_pkg
// Shared types and constants for the sync and length deframer.
// ----------------------------------------------------------------------------
package sld_pkg;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 16;
    localparam int IDX_W  = 2;

    localparam logic [IDX_W-1:0] CFG_SYNC_FIRST  = 2'd0;
    localparam logic [IDX_W-1:0] CFG_SYNC_SECOND = 2'd1;
    localparam logic [IDX_W-1:0] CFG_MAX_LENGTH  = 2'd2;

    localparam logic [BYTE_W-1:0] SYNC_FIRST_RESET  = 8'd148;
    localparam logic [BYTE_W-1:0] SYNC_SECOND_RESET = 8'd195;
    localparam logic [LEN_W-1:0]  MAX_LENGTH_RESET  = 16'd512;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_ERROR   = 1'b1;

    typedef enum logic [4:0] {
        PH_SYNC1   = 5'b00001,
        PH_SYNC2   = 5'b00010,
        PH_LEN_HI  = 5'b00100,
        PH_LEN_LO  = 5'b01000,
        PH_PAYLOAD = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0] sync_first;
        logic [BYTE_W-1:0] sync_second;
        logic [LEN_W-1:0]  max_length;
    } cfg_t;

    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] out_byte;
        logic              frame_end;
    } result_t;

endpackage

FILE: sv/sld_parser.sv
// ----------------------------------------------------------------------------
// sld_parser
// Frame parsing state machine; one byte per step, zero or one result.
// ----------------------------------------------------------------------------
module sld_parser (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     step,
    input  logic [sld_pkg::BYTE_W-1:0] data,
    input  sld_pkg::cfg_t            cfg,
    output logic                     res_valid,
    output sld_pkg::result_t         res
);
    import sld_pkg::*;

    phase_t            phase_reg, phase_next;
    logic [LEN_W-1:0]  frame_length_reg, frame_length_next;
    logic [LEN_W-1:0]  bytes_seen_reg, bytes_seen_next;
    logic [LEN_W-1:0]  length_word;
    logic [LEN_W:0]    seen_inc;
    logic              last;

    assign length_word = {frame_length_reg[LEN_W-1:BYTE_W], data};
    assign seen_inc    = {1'b0, bytes_seen_reg} + {{LEN_W{1'b0}}, 1'b1};
    assign last        = seen_inc >= {1'b0, frame_length_reg};

    always_comb
    begin
        phase_next        = phase_reg;
        frame_length_next = frame_length_reg;
        bytes_seen_next   = bytes_seen_reg;
        res_valid         = 1'b0;
        res.kind          = KIND_PAYLOAD;
        res.out_byte      = '0;
        res.frame_end     = 1'b0;
        case (phase_reg)
            PH_SYNC2:
            begin
                if (data == cfg.sync_second)
                begin
                    phase_next = PH_LEN_HI;
                end
                else if (data != cfg.sync_first)
                begin
                    phase_next = PH_SYNC1;
                end
            end
            PH_LEN_HI:
            begin
                frame_length_next = {data, {BYTE_W{1'b0}}};
                phase_next        = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                frame_length_next = length_word;
                if (length_word != '0 && length_word <= cfg.max_length)
                begin
                    bytes_seen_next = '0;
                    phase_next      = PH_PAYLOAD;
                end
                else
                begin
                    phase_next = PH_SYNC1;
                    res_valid  = 1'b1;
                    res.kind   = KIND_ERROR;
                end
            end
            PH_PAYLOAD:
            begin
                bytes_seen_next = seen_inc[LEN_W-1:0];
                if (last)
                begin
                    phase_next = PH_SYNC1;
                end
                res_valid     = 1'b1;
                res.out_byte  = data;
                res.frame_end = last;
            end
            default:
            begin
                if (data == cfg.sync_first)
                begin
                    phase_next = PH_SYNC2;
                end
                else
                begin
                    phase_next = PH_SYNC1;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_SYNC1;
            frame_length_reg <= '0;
            bytes_seen_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg        <= phase_next;
            frame_length_reg <= frame_length_next;
            bytes_seen_reg   <= bytes_seen_next;
        end
    end

endmodule

FILE: sv/sync_length_deframer.sv
// ----------------------------------------------------------------------------
// sync_length_deframer
// Hunts for two sync bytes, reads a 16-bit length and streams the payload.
// ----------------------------------------------------------------------------
// A result passes through the input register and then the result register.
// Throughput: one byte per cycle unless a result waits untaken; the input
// register loads whenever it is empty or its byte moves on, and the result
// register advances whenever it is empty or being taken.
// Reset: rst_n clears the handshake state, returns the parser to hunting for
// the first sync byte and loads the register reset values.
// ----------------------------------------------------------------------------
module sync_length_deframer (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write,
    input  logic [sld_pkg::IDX_W-1:0]  cfg_index,
    input  logic [sld_pkg::LEN_W-1:0]  cfg_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [sld_pkg::BYTE_W-1:0] in_byte,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       kind,
    output logic [sld_pkg::BYTE_W-1:0] out_byte,
    output logic                       frame_end
);
    import sld_pkg::*;

    cfg_t              cfg_reg;
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              out_valid_reg;
    result_t           out_reg;
    logic              advance;
    logic              step;
    logic              res_valid;
    result_t           res;

    assign advance  = !out_valid_reg || out_ready;
    assign step     = in_valid_reg && advance;
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_first  <= SYNC_FIRST_RESET;
            cfg_reg.sync_second <= SYNC_SECOND_RESET;
            cfg_reg.max_length  <= MAX_LENGTH_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_SYNC_FIRST:  cfg_reg.sync_first  <= cfg_data[BYTE_W-1:0];
                CFG_SYNC_SECOND: cfg_reg.sync_second <= cfg_data[BYTE_W-1:0];
                CFG_MAX_LENGTH:  cfg_reg.max_length  <= cfg_data;
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_byte_reg <= in_byte;
        end
    end

    sld_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .data      (in_byte_reg),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= step && res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = out_reg.kind;
    assign out_byte  = out_reg.out_byte;
    assign frame_end = out_reg.frame_end;

endmodule

FILE: dv/tb_sync_length_deframer.sv
// ----------------------------------------------------------------------------
// tb_sync_length_deframer
// Drives received bytes into the deframer under random handshake gaps and
// checks every output word against a cycle-free prediction of the parser.
// Several register settings are visited, including the widest and narrowest
// length limits, equal sync bytes, and a write to an unused register index.
// ----------------------------------------------------------------------------
module tb_sync_length_deframer;

    timeunit 1ns;
    timeprecision 1ps;

    import sld_pkg::*;

    localparam logic [IDX_W-1:0] CFG_UNUSED = 2'd3;

    class frame_tracker;
        logic [BYTE_W-1:0] first_sync;
        logic [BYTE_W-1:0] second_sync;
        logic [LEN_W-1:0]  len_limit;
        phase_t            phase;
        logic [LEN_W-1:0]  frame_len;
        logic [LEN_W-1:0]  bytes_out;
        result_t           due_words[$];
        int                fail_count;

        function new();
            first_sync  = SYNC_FIRST_RESET;
            second_sync = SYNC_SECOND_RESET;
            len_limit   = MAX_LENGTH_RESET;
            phase       = PH_SYNC1;
            frame_len   = '0;
            bytes_out   = '0;
            fail_count  = 0;
        endfunction

        function void set_reg(input logic [IDX_W-1:0] idx, input logic [LEN_W-1:0] data);
            case (idx)
                CFG_SYNC_FIRST:  first_sync  = data[BYTE_W-1:0];
                CFG_SYNC_SECOND: second_sync = data[BYTE_W-1:0];
                CFG_MAX_LENGTH:  len_limit   = data;
                default: ;
            endcase
        endfunction

        function void note_byte(input logic [BYTE_W-1:0] b);
            result_t word;
            logic    last;
            case (phase)
                PH_SYNC2:
                begin
                    if (b == second_sync)
                        phase = PH_LEN_HI;
                    else if (b != first_sync)
                        phase = PH_SYNC1;
                end
                PH_LEN_HI:
                begin
                    frame_len = {b, 8'h00};
                    phase     = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    frame_len[7:0] = b;
                    if (frame_len != '0 && frame_len <= len_limit)
                    begin
                        bytes_out = '0;
                        phase     = PH_PAYLOAD;
                    end
                    else
                    begin
                        phase          = PH_SYNC1;
                        word.kind      = KIND_ERROR;
                        word.out_byte  = '0;
                        word.frame_end = 1'b0;
                        due_words.push_back(word);
                    end
                end
                PH_PAYLOAD:
                begin
                    last      = ({1'b0, bytes_out} + 17'd1) >= {1'b0, frame_len};
                    bytes_out = bytes_out + 16'd1;
                    if (last)
                        phase = PH_SYNC1;
                    word.kind      = KIND_PAYLOAD;
                    word.out_byte  = b;
                    word.frame_end = last;
                    due_words.push_back(word);
                end
                default:
                begin
                    phase = (b == first_sync) ? PH_SYNC2 : PH_SYNC1;
                end
            endcase
        endfunction

        function void check_result(input logic got_kind, input logic [BYTE_W-1:0] got_byte,
                                   input logic got_end);
            result_t want;
            if (due_words.size() == 0)
            begin
                if (fail_count < 10)
                    $display("%0t: unexpected word kind=%0d byte=%02h end=%0d",
                             $time, got_kind, got_byte, got_end);
                fail_count++;
                return;
            end
            want = due_words.pop_front();
            if (got_kind !== want.kind || got_byte !== want.out_byte
                || got_end !== want.frame_end)
            begin
                if (fail_count < 10)
                    $display("%0t: expected %0d %02h %0d, got %0d %02h %0d",
                             $time, want.kind, want.out_byte, want.frame_end,
                             got_kind, got_byte, got_end);
                fail_count++;
            end
        endfunction

        function int waiting();
            return due_words.size();
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_write;
    logic [IDX_W-1:0]  cfg_index;
    logic [LEN_W-1:0]  cfg_data;
    logic              in_valid;
    logic              in_ready;
    logic [BYTE_W-1:0] in_byte;
    logic              out_valid;
    logic              out_ready;
    logic              kind;
    logic [BYTE_W-1:0] out_byte;
    logic              frame_end;

    frame_tracker tracker = new();
    int           items_sent = 0;
    int           tx_idle_pct = 0;
    int           rx_idle_pct = 0;
    bit           hold_go = 1'b0;
    logic         hold_rx;

    sync_length_deframer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_byte   (in_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .kind      (kind),
        .out_byte  (out_byte),
        .frame_end (frame_end)
    );

    always #4 clk = ~clk;

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct)
        begin
            gap = $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        tracker.note_byte(b);
        items_sent++;
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [LEN_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        tracker.set_reg(idx, data);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_quiet();
        in_valid <= 1'b0;
        while (tracker.waiting() != 0) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    function automatic int pick_length(input int lim);
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 10)
            return 0;
        if (sel < 25 && lim < 65535)
            return $urandom_range(lim + 1, 65535);
        if (sel < 32 && lim > 0 && lim <= 64)
            return lim;
        if (lim < 12)
            return (lim == 0) ? 1 : $urandom_range(1, lim);
        return $urandom_range(1, 12);
    endfunction

    task automatic send_frame(input int len, input int extra_syncs);
        send_byte(tracker.first_sync);
        repeat (extra_syncs) send_byte(tracker.first_sync);
        send_byte(tracker.second_sync);
        send_byte(len[15:8]);
        send_byte(len[7:0]);
        if (len != 0 && len <= int'(tracker.len_limit))
            repeat (len) send_byte($urandom_range(0, 255));
    endtask

    task automatic send_sequence();
        int shape;
        int reps;
        shape = $urandom_range(0, 99);
        if (shape < 70)
        begin
            reps = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
            send_frame(pick_length(int'(tracker.len_limit)), reps);
        end
        else if (shape < 85)
        begin
            send_byte(tracker.first_sync);
            send_byte($urandom_range(0, 255));
        end
        else
        begin
            send_byte($urandom_range(0, 255));
        end
    endtask

    task automatic run_random(input int count);
        int target;
        target = items_sent + count;
        while (items_sent < target) send_sequence();
    endtask

    initial
    begin : rx_hold
        hold_rx <= 1'b0;
        wait (hold_go);
        @(posedge clk);
        hold_rx <= 1'b1;
        repeat (200) @(posedge clk);
        hold_rx <= 1'b0;
    end

    initial
    begin : rx_side
        int stall_left;
        stall_left = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid === 1'b1 && out_ready === 1'b1)
                tracker.check_result(kind, out_byte, frame_end);
            if (hold_rx)
            begin
                out_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct)
            begin
                stall_left = $urandom_range(0, 5);
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    initial
    begin : watchdog
        #8ms;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin : main_flow
        logic [BYTE_W-1:0] opening [24];
        opening = '{8'd148, 8'd195, 8'h00, 8'h01, 8'hFF,
                    8'd148, 8'd148, 8'd148, 8'd195, 8'h00, 8'h02, 8'h00, 8'hA5,
                    8'd148, 8'h12,
                    8'd148, 8'd195, 8'h00, 8'h00,
                    8'd148, 8'd195, 8'h02, 8'h01,
                    8'hC3};
        rst_n     <= 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        in_byte   <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        tx_idle_pct = 20;
        rx_idle_pct = 20;
        foreach (opening[i])
            send_byte(opening[i]);
        hold_go = 1'b1;
        run_random(250);
        wait_quiet();

        write_reg(CFG_SYNC_FIRST, {8'($urandom_range(0, 255)), 8'h00});
        write_reg(CFG_SYNC_SECOND, {8'($urandom_range(0, 255)), 8'hFF});
        write_reg(CFG_MAX_LENGTH, 16'd1);
        write_reg(CFG_UNUSED, 16'hFFFF);
        run_random(200);
        wait_quiet();

        tx_idle_pct = 0;
        write_reg(CFG_SYNC_FIRST, 16'h005A);
        write_reg(CFG_SYNC_SECOND, 16'h005A);
        write_reg(CFG_MAX_LENGTH, 16'd40);
        run_random(200);
        wait_quiet();

        tx_idle_pct = 25;
        rx_idle_pct = 0;
        write_reg(CFG_SYNC_FIRST, 16'h00FF);
        write_reg(CFG_SYNC_SECOND, 16'h0000);
        write_reg(CFG_MAX_LENGTH, 16'd0);
        run_random(100);
        wait_quiet();

        tx_idle_pct = 0;
        write_reg(CFG_SYNC_FIRST, 16'($urandom_range(0, 255)));
        write_reg(CFG_SYNC_SECOND, 16'($urandom_range(0, 255)));
        write_reg(CFG_MAX_LENGTH, 16'hFFFF);
        run_random(250);
        wait_quiet();

        if (tracker.fail_count == 0 && tracker.waiting() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
